// File: design/tun_pkg.sv
// Shared constants and transaction types for the triangle unit normal block.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;

  // Vertex coordinate width and normal fraction width.
  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 15;

  // Cross components are scaled down until the largest magnitude fits here.
  localparam int MAG_BITS   = 15;
  // Sum of three squared magnitudes.
  localparam int LEN_BITS   = 2 * MAG_BITS + 2;
  // The squared length is scaled up by this before the square root (root in Q.15).
  localparam int LEN_SHIFT  = 30;
  localparam int RAD_BITS   = LEN_BITS + LEN_SHIFT;
  localparam int ROOT_BITS  = RAD_BITS / 2;

  // Entries of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_a_z;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_b_z;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] vertex_c_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [NORMAL_FRAC_BITS:0] normal_x;
    logic signed [NORMAL_FRAC_BITS:0] normal_y;
    logic signed [NORMAL_FRAC_BITS:0] normal_z;
    logic                             degenerate;
  } tun_out_t;

  // Scaled cross product magnitudes with their signs, as queued for the back end.
  typedef struct packed {
    logic [2:0][MAG_BITS-1:0] mag;
    logic [2:0]               neg;
    logic                     degenerate;
  } tun_job_t;

endpackage
`default_nettype wire

// File: design/tun_front.sv
// Front end: edge vectors, cross product and common scaling of the components.
`timescale 1ns / 1ps
`default_nettype none
module tun_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tun_pkg::tun_in_t  item_i,
  input  logic              full_i,
  output logic              stall_o,
  output logic              push_o,
  output tun_pkg::tun_job_t job_o
);

  localparam int CB  = tun_pkg::COORD_BITS;
  localparam int MB  = tun_pkg::MAG_BITS;
  localparam int DW  = CB + 1;
  localparam int PW  = 2 * DW;
  localparam int XW  = PW + 1;
  localparam int SHW = $clog2(XW + 1);

  logic [4:0] vld_q;
  logic       adv;

  logic signed [DW-1:0] u_q [3];
  logic signed [DW-1:0] v_q [3];
  logic signed [PW-1:0] p_q [6];
  logic [XW-1:0]        mag3_q [3];
  logic [2:0]           neg3_q;
  logic [XW-1:0]        mag4_q [3];
  logic [2:0]           neg4_q;
  logic                 degen4_q;
  logic [SHW-1:0]       sh_q;
  tun_pkg::tun_job_t    job_q;

  logic signed [PW-1:0] p_d [6];
  logic signed [XW-1:0] cr_d [3];
  logic [XW-1:0]        mag3_d [3];
  logic [2:0]           neg3_d;
  logic [XW-1:0]        or_d;
  logic [SHW-1:0]       blen_d;
  logic [SHW-1:0]       sh_d;
  tun_pkg::tun_job_t    job_d;

  assign adv     = !(vld_q[4] && full_i);
  assign stall_o = !adv;
  assign push_o  = vld_q[4] && !full_i;
  assign job_o   = job_q;

  always_comb begin
    p_d[0] = u_q[1] * v_q[2];
    p_d[1] = v_q[1] * u_q[2];
    p_d[2] = u_q[2] * v_q[0];
    p_d[3] = v_q[2] * u_q[0];
    p_d[4] = u_q[0] * v_q[1];
    p_d[5] = v_q[0] * u_q[1];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d[i]   = XW'(p_q[2*i]) - XW'(p_q[2*i+1]);
      neg3_d[i] = cr_d[i][XW-1];
      mag3_d[i] = neg3_d[i] ? XW'(-cr_d[i]) : XW'(cr_d[i]);
    end
  end

  // Bit length of the largest magnitude equals that of the OR of all three.
  always_comb begin
    or_d   = mag3_q[0] | mag3_q[1] | mag3_q[2];
    blen_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (or_d[i]) begin
        blen_d = SHW'(i + 1);
      end
    end
    sh_d = (blen_d > SHW'(MB)) ? (blen_d - SHW'(MB)) : '0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job_d.mag[i] = MB'(mag4_q[i] >> sh_q);
    end
    job_d.neg        = neg4_q;
    job_d.degenerate = degen4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q[0] <= DW'(item_i.vertex_c_x) - DW'(item_i.vertex_b_x);
      u_q[1] <= DW'(item_i.vertex_c_y) - DW'(item_i.vertex_b_y);
      u_q[2] <= DW'(item_i.vertex_c_z) - DW'(item_i.vertex_b_z);
      v_q[0] <= DW'(item_i.vertex_a_x) - DW'(item_i.vertex_b_x);
      v_q[1] <= DW'(item_i.vertex_a_y) - DW'(item_i.vertex_b_y);
      v_q[2] <= DW'(item_i.vertex_a_z) - DW'(item_i.vertex_b_z);
      p_q      <= p_d;
      mag3_q   <= mag3_d;
      neg3_q   <= neg3_d;
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
      degen4_q <= (or_d == '0);
      sh_q     <= sh_d;
      job_q    <= job_d;
    end
  end

endmodule
`default_nettype wire

// File: design/tun_fifo.sv
// Short queue of scaled cross products between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module tun_fifo #(
  parameter int Depth = tun_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tun_pkg::tun_job_t data_i,
  output logic              full_o,
  output logic              valid_o,
  output tun_pkg::tun_job_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tun_pkg::tun_job_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;

  // The back end never stalls: drain one entry whenever any is held.
  assign pop     = (cnt_q != '0);
  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CntW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: design/tun_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tun_sqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [tun_pkg::LEN_BITS-1:0]     len_i,
  input  tun_pkg::tun_job_t                job_i,
  output logic                             valid_o,
  output logic [tun_pkg::ROOT_BITS-1:0]    root_o,
  output tun_pkg::tun_job_t                job_o
);

  localparam int NS  = tun_pkg::ROOT_BITS;
  localparam int LW  = tun_pkg::LEN_BITS;
  localparam int RTW = tun_pkg::ROOT_BITS;
  localparam int RW  = RTW + 2;
  localparam int RadW = tun_pkg::RAD_BITS;
  localparam int LenShift = tun_pkg::LEN_SHIFT;

  logic [NS-1:0]     vld_q;
  logic [LW-1:0]     len_q  [NS];
  logic [RW-1:0]     rem_q  [NS];
  logic [RTW-1:0]    root_q [NS];
  tun_pkg::tun_job_t job_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int Hi = RadW - 1 - 2 * k;
    logic              vld_in;
    logic [LW-1:0]     len_in;
    logic [RW-1:0]     rem_in;
    logic [RTW-1:0]    root_in;
    tun_pkg::tun_job_t job_in;
    logic [1:0]        pair;
    logic [RW-1:0]     rem_sh, trial;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign len_in  = len_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign job_in  = job_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign len_in  = len_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign job_in  = job_q[k-1];
    end

    // Radicand is the length shifted up, so its low pairs are zero.
    if (Hi - 1 >= LenShift) begin : g_pair
      assign pair = len_in[Hi-LenShift -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_sh = {rem_in[RW-3:0], pair};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k] <= len_in;
      job_q[k] <= job_in;
      if (rem_sh >= trial) begin
        rem_q[k]  <= rem_sh - trial;
        root_q[k] <= {root_in[RTW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_sh;
        root_q[k] <= {root_in[RTW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign job_o   = job_q[NS-1];

endmodule
`default_nettype wire

// File: design/tun_div.sv
// Pipelined rounding division of each magnitude by the length, with sign and saturation.
`timescale 1ns / 1ps
`default_nettype none
module tun_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [tun_pkg::ROOT_BITS-1:0] root_i,
  input  tun_pkg::tun_job_t             job_i,
  output logic                          done_o,
  output tun_pkg::tun_out_t             result_o
);

  localparam int NFB  = tun_pkg::NORMAL_FRAC_BITS;
  localparam int MB   = tun_pkg::MAG_BITS;
  localparam int RTW  = tun_pkg::ROOT_BITS;
  localparam int NumShift = NFB + tun_pkg::LEN_SHIFT / 2;
  localparam int DVW  = MB + NumShift + 1;
  localparam int QB   = NFB + 2;
  localparam int RW   = RTW + 1;

  // Preparation stage: rounded dividend and initial remainder.
  logic                 pv_q;
  logic [RTW-1:0]       proot_q;
  tun_pkg::tun_job_t    pjob_q;
  logic [RW-1:0]        prem_q [3];
  logic [QB-1:0]        plow_q [3];
  logic [DVW-1:0]       dvd_d  [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dvd_d[l] = (DVW'(job_i.mag[l]) << NumShift) + DVW'(root_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    proot_q <= root_i;
    pjob_q  <= job_i;
    for (int l = 0; l < 3; l++) begin
      prem_q[l] <= RW'(dvd_d[l] >> QB);
      plow_q[l] <= dvd_d[l][QB-1:0];
    end
  end

  logic [QB-1:0]     vld_q;
  logic [RTW-1:0]    root_q [QB];
  tun_pkg::tun_job_t job_q  [QB];
  logic [RW-1:0]     rem_q  [QB][3];
  logic [QB-1:0]     low_q  [QB][3];
  logic [QB-1:0]     quo_q  [QB][3];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic              vld_in;
    logic [RTW-1:0]    root_in;
    tun_pkg::tun_job_t job_in;
    logic [RW-1:0]     rem_in [3];
    logic [QB-1:0]     low_in [3];
    logic [QB-1:0]     quo_in [3];
    logic [RW-1:0]     rem_sh [3];

    if (k == 0) begin : g_first
      assign vld_in  = pv_q;
      assign root_in = proot_q;
      assign job_in  = pjob_q;
      assign rem_in  = prem_q;
      assign low_in  = plow_q;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          quo_in[l] = '0;
        end
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign root_in = root_q[k-1];
      assign job_in  = job_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_sh[l] = {rem_in[l][RW-2:0], low_in[l][QB-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[k] <= root_in;
      job_q[k]  <= job_in;
      for (int l = 0; l < 3; l++) begin
        low_q[k][l] <= low_in[l] << 1;
        if (rem_sh[l] >= {1'b0, root_in}) begin
          rem_q[k][l] <= rem_sh[l] - {1'b0, root_in};
          quo_q[k][l] <= {quo_in[l][QB-2:0], 1'b1};
        end else begin
          rem_q[k][l] <= rem_sh[l];
          quo_q[k][l] <= {quo_in[l][QB-2:0], 1'b0};
        end
      end
    end
  end

  // Saturate a full-length component, apply the sign, clear a degenerate normal.
  logic [NFB:0]       nrm_d [3];
  logic [QB-1:0]      sat_d [3];
  tun_pkg::tun_out_t  res_d, res_q;
  logic               done_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sat_d[l] = (quo_q[QB-1][l] > QB'((1 << NFB) - 1)) ? QB'((1 << NFB) - 1)
                                                           : quo_q[QB-1][l];
      nrm_d[l] = job_q[QB-1].neg[l] ? (NFB+1)'(-sat_d[l]) : (NFB+1)'(sat_d[l]);
      if (job_q[QB-1].degenerate) begin
        nrm_d[l] = '0;
      end
    end
    res_d.normal_x   = nrm_d[0];
    res_d.normal_y   = nrm_d[1];
    res_d.normal_z   = nrm_d[2];
    res_d.degenerate = job_q[QB-1].degenerate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

// File: design/tun_back.sv
// Back end: squared length, square root and division to the unit normal.
`timescale 1ns / 1ps
`default_nettype none
module tun_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tun_pkg::tun_job_t job_i,
  output logic              done_o,
  output tun_pkg::tun_out_t result_o
);

  localparam int MB = tun_pkg::MAG_BITS;
  localparam int LW = tun_pkg::LEN_BITS;

  logic [1:0]           vld_q;
  logic [2*MB-1:0]      sq_q [3];
  tun_pkg::tun_job_t    job1_q, job2_q;
  logic [LW-1:0]        len_q;

  logic                          sq_valid;
  logic [tun_pkg::ROOT_BITS-1:0] sq_root;
  tun_pkg::tun_job_t             sq_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= job_i.mag[i] * job_i.mag[i];
    end
    job1_q <= job_i;
    len_q  <= LW'(sq_q[0]) + LW'(sq_q[1]) + LW'(sq_q[2]);
    job2_q <= job1_q;
  end

  tun_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[1]),
    .len_i   (len_q),
    .job_i   (job2_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .job_o   (sq_job)
  );

  tun_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_valid),
    .root_i   (sq_root),
    .job_i    (sq_job),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

// File: design/triangle_unit_normal_unit.sv
// Top level of the triangle unit normal block.
`timescale 1ns / 1ps
`default_nettype none
// Unit face normal of a triangle. Present vertices A, B and C on item_i with start high; the
// transaction is taken at a rising edge where busy is low. The block forms (C - B) x (A - B),
// scales the three components down together so the largest fits in 15 bits, takes the length
// by square root and divides each component by it, giving a Q1.15 normal rounded to nearest.
// A zero cross product raises degenerate with a zero normal. One transaction can be taken in
// every cycle while busy is low; the result passes through the 31-stage square root and the
// 17 quotient stages of the divider, and is shown on result_o for exactly one cycle with
// done_o high. The receiver cannot hold results off, so the back end never stalls and busy
// stays low in normal use; it only rises if the queue between front and back were full.
module triangle_unit_normal_unit #(
  parameter int QueueDepth = tun_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tun_pkg::tun_in_t  item_i,
  output logic              done_o,
  output tun_pkg::tun_out_t result_o
);

  logic              accept;
  logic              stall;
  logic              push;
  logic              full;
  tun_pkg::tun_job_t front_job;
  logic              queue_valid;
  tun_pkg::tun_job_t queue_job;

  // Take a transaction only while the front pipeline can advance.
  assign busy   = stall;
  assign accept = start && !busy;

  // Front: edge vectors, cross product, common scaling.
  tun_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .full_i  (full),
    .stall_o (stall),
    .push_o  (push),
    .job_o   (front_job)
  );

  // Queue: decouple the front from the back end.
  tun_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .valid_o (queue_valid),
    .data_o  (queue_job)
  );

  // Back: length, square root, rounding division and sign.
  tun_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (queue_valid),
    .job_i    (queue_job),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire
